/* rtl/core/glcd_pkg.sv */
// Shared types and constants for the multiplexed LCD drive block.
package glcd_pkg;

    // Frame geometry
    localparam int NUM_COMMONS    = 4;
    localparam int SEG_LINE_COUNT = 16;
    localparam int COM_W          = 2;
    localparam int SEG_BIT_W      = 4;
    localparam int LEVEL_W        = 2;
    localparam int DRIVE_W        = NUM_COMMONS * LEVEL_W;

    // Request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // Bit operations for a frame buffer write
    localparam logic [1:0] OP_ON     = 2'd0;
    localparam logic [1:0] OP_OFF    = 2'd1;
    localparam logic [1:0] OP_TOGGLE = 2'd2;

    // Common line levels
    localparam logic [LEVEL_W-1:0] COM_LOW  = 2'd0;
    localparam logic [LEVEL_W-1:0] COM_HIGH = 2'd1;
    localparam logic [LEVEL_W-1:0] COM_HALF = 2'd2;

    // Drive phase codes on the result
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRUE = 2'd1;
    localparam logic [1:0] PH_INV  = 2'd2;

    // Phase sequencer: idle, true, idle, inverted, repeat
    typedef enum logic [1:0] {
        PS_IDLE_TO_TRUE,
        PS_TRUE,
        PS_IDLE_TO_INV,
        PS_INV
    } phase_state_t;

    typedef struct packed {
        logic                 req_type;
        logic [COM_W-1:0]     com_index;
        logic [SEG_BIT_W-1:0] segment_bit;
        logic [1:0]           bit_op;
    } req_t;

    typedef struct packed {
        logic [SEG_LINE_COUNT-1:0] seg_lines;
        logic [DRIVE_W-1:0]        com_drive;
        logic [1:0]                drive_phase;
        logic [COM_W-1:0]          com_selected;
    } res_t;

endpackage

/* rtl/core/glcd_if.sv */
// Request and result channel interfaces with valid/ready handshake.
interface glcd_req_if;
    import glcd_pkg::*;

    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface glcd_res_if;
    import glcd_pkg::*;

    logic valid;
    logic ready;
    res_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/glcd_wave.sv */
// Frame buffer, phase sequencer and waveform forming for one request.
module glcd_wave (
    input  logic          clk,
    input  logic          rst_n,
    input  glcd_pkg::req_t item,
    input  logic          fire,
    output glcd_pkg::res_t result
);
    import glcd_pkg::*;

    logic [SEG_LINE_COUNT-1:0] fb_reg  [NUM_COMMONS];
    logic [SEG_LINE_COUNT-1:0] fb_next [NUM_COMMONS];
    phase_state_t              state_reg;
    phase_state_t              state_next;
    logic [COM_W-1:0]          common_reg;
    logic [COM_W-1:0]          common_next;

    logic                      is_write;
    logic                      is_tick;
    logic [SEG_LINE_COUNT-1:0] bit_mask;
    logic [SEG_LINE_COUNT-1:0] row;
    logic [1:0]                phase;
    logic [LEVEL_W-1:0]        sel_level;
    logic                      drive_on;
    logic [DRIVE_W-1:0]        drive;
    logic [SEG_LINE_COUNT-1:0] seg;
    logic                      step_common;

    assign is_write = fire && (item.req_type == REQ_WRITE);
    assign is_tick  = fire && (item.req_type == REQ_TICK);
    assign bit_mask = SEG_LINE_COUNT'(1) << item.segment_bit;

    // Update each row on a write aimed at it
    for (genvar c = 0; c < NUM_COMMONS; c++) begin : g_row
        always_comb
        begin
            fb_next[c] = fb_reg[c];
            if (is_write && (item.com_index == COM_W'(c)))
            begin
                case (item.bit_op)
                    OP_ON:   fb_next[c] = fb_reg[c] | bit_mask;
                    OP_OFF:  fb_next[c] = fb_reg[c] & ~bit_mask;
                    default: fb_next[c] = fb_reg[c] ^ bit_mask;
                endcase
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                fb_reg[c] <= '0;
            else
                fb_reg[c] <= fb_next[c];
        end
    end

    // Advance the phase sequencer on each tick
    always_comb
    begin
        state_next = state_reg;
        if (is_tick)
        begin
            case (state_reg)
                PS_IDLE_TO_TRUE: state_next = PS_TRUE;
                PS_TRUE:         state_next = PS_IDLE_TO_INV;
                PS_IDLE_TO_INV:  state_next = PS_INV;
                PS_INV:          state_next = PS_IDLE_TO_TRUE;
                default:         state_next = PS_IDLE_TO_TRUE;
            endcase
        end
    end

    // Decode phase, common level and segment polarity from the state
    always_comb
    begin
        phase       = PH_IDLE;
        sel_level   = COM_LOW;
        drive_on    = 1'b0;
        step_common = 1'b0;
        seg         = '0;
        case (state_reg)
            PS_TRUE:
            begin
                phase     = PH_TRUE;
                sel_level = COM_LOW;
                drive_on  = 1'b1;
                seg       = row;
            end
            PS_INV:
            begin
                phase       = PH_INV;
                sel_level   = COM_HIGH;
                drive_on    = 1'b1;
                step_common = 1'b1;
                seg         = ~row;
            end
            default:
            begin
                phase = PH_IDLE;
            end
        endcase
    end

    assign row = fb_reg[common_reg];

    // Selected common at its level, the others at half supply; all low when idle
    always_comb
    begin
        drive = '0;
        if (drive_on)
        begin
            for (int c = 0; c < NUM_COMMONS; c++)
            begin
                drive[c*LEVEL_W +: LEVEL_W] = (common_reg == COM_W'(c)) ? sel_level : COM_HALF;
            end
        end
    end

    // Move to the next common after the inverted phase
    always_comb
    begin
        common_next = common_reg;
        if (is_tick && step_common)
        begin
            if (common_reg == COM_W'(NUM_COMMONS - 1))
                common_next = '0;
            else
                common_next = common_reg + COM_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= PS_IDLE_TO_TRUE;
            common_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            common_reg <= common_next;
        end
    end

    assign result.seg_lines    = seg;
    assign result.com_drive    = drive;
    assign result.drive_phase  = phase;
    assign result.com_selected = common_reg;

endmodule

/* rtl/core/gpio_lcd_mux_drive.sv */
// Top level of the four-common multiplexed LCD waveform generator.
//
//   channel  dir  payload                                          handshake
//   req      in   req_type, com_index, segment_bit, bit_op         valid/ready
//   res      out  seg_lines, com_drive, drive_phase, com_selected  valid/ready
//
// One request per cycle unless the result stalls: a request is held in an
// input register, worked in one pass through the frame buffer and phase
// sequencer; a tick lands in the result register. A write gives no result.
// Reset (rst_n low, asynchronous) clears the frame buffer, the sequencer and
// both valid flags. A stalled result holds the result register; the input
// register still drains writes and takes a new request once it moves on.
module gpio_lcd_mux_drive (
    input logic        clk,
    input logic        rst_n,
    glcd_req_if.sink   req,
    glcd_res_if.source res
);
    import glcd_pkg::*;

    req_t s1_reg;
    logic s1_valid_reg;
    logic s1_valid_next;
    res_t res_data_reg;
    logic res_valid_reg;
    logic res_valid_next;

    logic req_fire;
    logic s1_is_write;
    logic out_free;
    logic s1_advance;
    logic res_load;
    res_t wave_res;

    // Handshake and stage control
    assign out_free    = !res_valid_reg || res.ready;
    assign s1_is_write = (s1_reg.req_type == REQ_WRITE);
    assign s1_advance  = s1_valid_reg && (s1_is_write || out_free);
    assign req.ready   = !s1_valid_reg || s1_advance;
    assign req_fire    = req.valid && req.ready;
    assign res_load    = s1_advance && !s1_is_write;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_fire)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
            res_valid_next = 1'b1;
        else if (res.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Capture the request and the formed result
    always_ff @(posedge clk)
    begin
        if (req_fire)
            s1_reg <= req.data;
        if (res_load)
            res_data_reg <= wave_res;
    end

    glcd_wave u_wave (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (s1_reg),
        .fire   (s1_advance),
        .result (wave_res)
    );

    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

`ifndef NO_ASSERTIONS
    // A write never raises a result
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_is_write && !res_valid_reg) |=> !res_valid_reg)
        else $error("write request produced a result");

    // An idle phase result drives nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.drive_phase == PH_IDLE) |->
        (res_data_reg.seg_lines == '0 && res_data_reg.com_drive == '0))
        else $error("idle phase result not all low");

    // The selected common is low in the true phase and high in the inverted one
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.drive_phase == PH_TRUE) |->
        (res_data_reg.com_drive[res_data_reg.com_selected*LEVEL_W +: LEVEL_W] == COM_LOW))
        else $error("selected common not low in true phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.drive_phase == PH_INV) |->
        (res_data_reg.com_drive[res_data_reg.com_selected*LEVEL_W +: LEVEL_W] == COM_HIGH))
        else $error("selected common not high in inverted phase");

    // A held request is neither lost nor replaced
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("held request overwritten");
`endif

endmodule
